### rtl/svrs_pkg.sv
// ----------------------------------------------------------------------------
// svrs_pkg
// Shared types and constants of the sliding window rate statistics block.
// ----------------------------------------------------------------------------
package svrs_pkg;

  localparam logic [27:0] RATE_NUM = 28'd256000000;
  localparam int unsigned SUM_W    = 35;
  localparam int unsigned DVD_W    = 64;
  localparam int unsigned DVS_W    = 28;

  localparam logic [1:0] DIV_RATE = 2'd0;
  localparam logic [1:0] DIV_MEAN = 2'd1;
  localparam logic [1:0] DIV_VAR  = 2'd2;
  localparam logic [1:0] DIV_MFT  = 2'd3;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_sel;
    logic       wr;
    logic       init;
    logic       run1;
    logic       run2;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic pass_busy;
  } sts_t;

endpackage

### rtl/sliding_window_rate_stats_top.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_stats_top
// Frame rate statistics over a sliding window of recent frame rates.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                   Payload
//  in       input      in_valid_i / in_stall_o     frame_time_us_i
//  out      output     out_valid_o / out_stall_i   rate, min, max, mean, ...
//  cfg      input      APB write/read, pready = 1  window_size, drop threshold
//
// Each item runs four 64-step divisions in one shared bit-serial divider
// and two passes over the history RAM, one read per cycle, which cover the
// n entries of the window fill.
// Reset clears the counters, the fill count and the head pointer; the history
// RAM is not cleared, since only written entries are ever read.
// A finished result waits in the output registers while the next item is
// already accepted and worked on; output stall only delays the final load.
//
module sliding_window_rate_stats_top #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] frame_time_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [27:0] current_rate_o,
  output logic [27:0] min_rate_o,
  output logic [27:0] max_rate_o,
  output logic [27:0] mean_rate_o,
  output logic [55:0] rate_variance_o,
  output logic [23:0] mean_frame_time_us_o,
  output logic        mean_zero_o,
  output logic [31:0] frames_seen_o,
  output logic [31:0] frames_dropped_o,
  output logic [6:0]  window_fill_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. Register i sits at byte address 4*i.
  logic [6:0]  window_size_q;
  logic [23:0] drop_threshold_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q    <= 7'd60;
      drop_threshold_q <= 24'd16670;
    end else if (cfg_wr) begin
      case (paddr[2])
        svrs_pkg::REG_WINDOW: window_size_q    <= pwdata[6:0];
        svrs_pkg::REG_THRESH: drop_threshold_q <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      svrs_pkg::REG_WINDOW: prdata = {25'd0, window_size_q};
      svrs_pkg::REG_THRESH: prdata = {8'd0, drop_threshold_q};
      default:              prdata = '0;
    endcase
  end

  svrs_pkg::cmd_t cmd;
  svrs_pkg::sts_t sts;

  // The controller only sequences; every value lives in the datapath.
  svrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  svrs_dp #(.DEPTH(HISTORY_DEPTH)) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .frame_time_us_i      (frame_time_us_i),
    .window_size_i        (window_size_q),
    .drop_threshold_us_i  (drop_threshold_q),
    .current_rate_o       (current_rate_o),
    .min_rate_o           (min_rate_o),
    .max_rate_o           (max_rate_o),
    .mean_rate_o          (mean_rate_o),
    .rate_variance_o      (rate_variance_o),
    .mean_frame_time_us_o (mean_frame_time_us_o),
    .mean_zero_o          (mean_zero_o),
    .frames_seen_o        (frames_seen_o),
    .frames_dropped_o     (frames_dropped_o),
    .window_fill_o        (window_fill_o)
  );

  // An accepted item keeps the input stalled while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // The mean always lies between the window extremes.
  a_mean_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_rate_o <= mean_rate_o && mean_rate_o <= max_rate_o))
    else $error("mean outside of min and max");

  // A delivered result always covers at least one rate.
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_fill_o != 7'd0))
    else $error("empty window in a result");

  // A zero mean saturates the mean frame time.
  a_mean_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mean_zero_o) |-> (mean_frame_time_us_o == 24'hFFFFFF))
    else $error("zero mean without saturated frame time");

endmodule

### rtl/svrs_ram.sv
// ----------------------------------------------------------------------------
// svrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module svrs_ram #(
  parameter int unsigned W = 28,
  parameter int unsigned D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/svrs_div.sv
// ----------------------------------------------------------------------------
// svrs_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module svrs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [svrs_pkg::DVD_W-1:0] dividend_i,
  input  logic [svrs_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [svrs_pkg::DVD_W-1:0] quo_o,
  output logic [svrs_pkg::DVS_W-1:0] rem_o
);

  logic [svrs_pkg::DVD_W-1:0] quo_q;
  logic [svrs_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [6:0]                 cnt_q;
  logic                       done_q;
  logic [svrs_pkg::DVS_W:0]   shifted, diff;
  logic                       ge;

  assign shifted = {rem_q, quo_q[svrs_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 7'(svrs_pkg::DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 7'd1;
        done_q <= (cnt_q == 7'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[svrs_pkg::DVD_W-2:0], ge};
      rem_q <= ge ? diff[svrs_pkg::DVS_W-1:0] : shifted[svrs_pkg::DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

### rtl/svrs_dp.sv
// ----------------------------------------------------------------------------
// svrs_dp
// Datapath: history RAM, window passes, shared divider and result registers.
// ----------------------------------------------------------------------------
module svrs_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svrs_pkg::cmd_t     cmd_i,
  output svrs_pkg::sts_t     sts_o,
  input  logic [23:0]        frame_time_us_i,
  input  logic [6:0]         window_size_i,
  input  logic [23:0]        drop_threshold_us_i,
  output logic [27:0]        current_rate_o,
  output logic [27:0]        min_rate_o,
  output logic [27:0]        max_rate_o,
  output logic [27:0]        mean_rate_o,
  output logic [55:0]        rate_variance_o,
  output logic [23:0]        mean_frame_time_us_o,
  output logic               mean_zero_o,
  output logic [31:0]        frames_seen_o,
  output logic [31:0]        frames_dropped_o,
  output logic [6:0]         window_fill_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [23:0]   ft_q;
  logic [27:0]   last_rate_q;
  logic [31:0]   frames_q, drops_q;
  logic [AW-1:0] head_q, ptr_q;
  logic [CW-1:0] n_q, iss_q, w_eff, n_d;
  logic [31:0]   win_ext, cnt_ext;
  logic          v1_q, v2_q, v3_q, first_q, issue;
  logic [27:0]   rd_data, mn_q, mx_q, d_q, mean_q;
  logic [55:0]   prod_q;
  logic [svrs_pkg::SUM_W-1:0] sum_q;
  logic [63:0]   dsum_q, q_q, var_d;
  logic [6:0]    remm_q, r1_q;
  logic [23:0]   mft_q;
  logic [1:0]    sel_q;
  logic          dec;
  logic [13:0]   lhs, rhs;

  logic [svrs_pkg::DVD_W-1:0] dvd, quo;
  logic [svrs_pkg::DVS_W-1:0] dvs, rem;
  logic                       div_done;

  always_comb begin
    win_ext = {25'd0, window_size_i};
    if (win_ext == 32'd0) begin
      w_eff = CW'(1);
    end else if (win_ext > 32'(DEPTH)) begin
      w_eff = CW'(DEPTH);
    end else begin
      w_eff = CW'(win_ext);
    end
    cnt_ext = 32'(n_q) + 32'd1;
    n_d = (cnt_ext > 32'(w_eff)) ? w_eff : CW'(cnt_ext);
  end

  always_comb begin
    case (cmd_i.div_sel)
      svrs_pkg::DIV_RATE: begin
        dvd = 64'(svrs_pkg::RATE_NUM);
        dvs = 28'(ft_q);
      end
      svrs_pkg::DIV_MEAN: begin
        dvd = 64'(sum_q);
        dvs = 28'(n_q);
      end
      svrs_pkg::DIV_VAR: begin
        dvd = dsum_q;
        dvs = 28'(n_q);
      end
      default: begin
        dvd = 64'(svrs_pkg::RATE_NUM);
        dvs = mean_q;
      end
    endcase
  end

  svrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  svrs_ram #(.W(28), .D(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (head_q),
    .wdata_i (last_rate_q),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  assign issue = (cmd_i.run1 || cmd_i.run2) && (iss_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_rate_q <= '0;
      frames_q    <= '0;
      drops_q     <= '0;
      head_q      <= '0;
      n_q         <= '0;
      iss_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        frames_q <= frames_q + 32'd1;
        if (frame_time_us_i > drop_threshold_us_i) begin
          drops_q <= drops_q + 32'd1;
        end
      end
      if (div_done && sel_q == svrs_pkg::DIV_RATE && ft_q != '0) begin
        last_rate_q <= quo[27:0];
      end
      if (cmd_i.wr) begin
        head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        n_q    <= n_d;
      end
      if (cmd_i.init) begin
        iss_q <= n_q;
      end else if (issue) begin
        iss_q <= iss_q - CW'(1);
      end
      v1_q <= issue;
      v2_q <= v1_q && cmd_i.run2;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ft_q <= frame_time_us_i;
    end
    if (cmd_i.div_start) begin
      sel_q <= cmd_i.div_sel;
    end
    if (cmd_i.init) begin
      ptr_q   <= (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
      sum_q   <= '0;
      dsum_q  <= '0;
      first_q <= 1'b1;
    end else if (issue) begin
      ptr_q <= (ptr_q == '0) ? AW'(DEPTH - 1) : ptr_q - AW'(1);
    end
    if (v1_q && cmd_i.run1) begin
      sum_q   <= sum_q + svrs_pkg::SUM_W'(rd_data);
      first_q <= 1'b0;
      if (first_q || rd_data < mn_q) begin
        mn_q <= rd_data;
      end
      if (first_q || rd_data > mx_q) begin
        mx_q <= rd_data;
      end
    end
    if (v1_q && cmd_i.run2) begin
      d_q <= (rd_data >= mean_q) ? rd_data - mean_q : mean_q - rd_data;
    end
    if (v2_q) begin
      prod_q <= 56'(d_q) * 56'(d_q);
    end
    if (v3_q) begin
      dsum_q <= dsum_q + 64'(prod_q);
    end
    if (div_done) begin
      case (sel_q)
        svrs_pkg::DIV_MEAN: begin
          mean_q <= quo[27:0];
          remm_q <= rem[6:0];
        end
        svrs_pkg::DIV_VAR: begin
          q_q  <= quo;
          r1_q <= rem[6:0];
        end
        svrs_pkg::DIV_MFT: begin
          mft_q <= (quo[63:24] != '0) ? 24'hFFFFFF : quo[23:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Exact floor of the rational variance: take one off when r1*n < rem^2.
  always_comb begin
    lhs   = 14'(r1_q) * 14'(7'(n_q));
    rhs   = 14'(remm_q) * 14'(remm_q);
    dec   = lhs < rhs;
    var_d = (dec && q_q != '0) ? q_q - 64'd1 : q_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      current_rate_o       <= last_rate_q;
      min_rate_o           <= mn_q;
      max_rate_o           <= mx_q;
      mean_rate_o          <= mean_q;
      rate_variance_o      <= (var_d[63:56] != '0) ? {56{1'b1}} : var_d[55:0];
      mean_frame_time_us_o <= (mean_q == '0) ? 24'hFFFFFF : mft_q;
      mean_zero_o          <= (mean_q == '0);
      frames_seen_o        <= frames_q;
      frames_dropped_o     <= drops_q;
      window_fill_o        <= 7'(n_q);
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.pass_busy = (iss_q != '0) || v1_q || v2_q || v3_q;

endmodule

### rtl/svrs_ctrl.sv
// ----------------------------------------------------------------------------
// svrs_ctrl
// Controller: sequences divisions and window passes, owns the handshakes.
// ----------------------------------------------------------------------------
module svrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  svrs_pkg::sts_t sts_i,
  output svrs_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DR    = 4'd1;
  localparam logic [3:0] S_DRW   = 4'd2;
  localparam logic [3:0] S_WR    = 4'd3;
  localparam logic [3:0] S_INIT1 = 4'd4;
  localparam logic [3:0] S_P1    = 4'd5;
  localparam logic [3:0] S_DM    = 4'd6;
  localparam logic [3:0] S_DMW   = 4'd7;
  localparam logic [3:0] S_INIT2 = 4'd8;
  localparam logic [3:0] S_P2    = 4'd9;
  localparam logic [3:0] S_DV    = 4'd10;
  localparam logic [3:0] S_DVW   = 4'd11;
  localparam logic [3:0] S_DT    = 4'd12;
  localparam logic [3:0] S_DTW   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_load;

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DR;
        end
      end
      S_DR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = svrs_pkg::DIV_RATE;
        state_d         = S_DRW;
      end
      S_DRW:   if (sts_i.div_done) state_d = S_WR;
      S_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = S_INIT1;
      end
      S_INIT1: begin
        cmd_o.init = 1'b1;
        state_d    = S_P1;
      end
      S_P1: begin
        cmd_o.run1 = 1'b1;
        if (!sts_i.pass_busy) state_d = S_DM;
      end
      S_DM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = svrs_pkg::DIV_MEAN;
        state_d         = S_DMW;
      end
      S_DMW:   if (sts_i.div_done) state_d = S_INIT2;
      S_INIT2: begin
        cmd_o.init = 1'b1;
        state_d    = S_P2;
      end
      S_P2: begin
        cmd_o.run2 = 1'b1;
        if (!sts_i.pass_busy) state_d = S_DV;
      end
      S_DV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = svrs_pkg::DIV_VAR;
        state_d         = S_DVW;
      end
      S_DVW:   if (sts_i.div_done) state_d = S_DT;
      S_DT: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = svrs_pkg::DIV_MFT;
        state_d         = S_DTW;
      end
      S_DTW:   if (sts_i.div_done) state_d = S_DONE;
      S_DONE: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### tb/sliding_window_rate_stats_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_stats_top_test
// Self-checking test of the frame rate statistics block. A scoreboard class
// keeps its own rate window and counters, predicts each result from the
// accepted frame times, and compares every output item field by field.
// ----------------------------------------------------------------------------
module sliding_window_rate_stats_top_test;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned CYC_LIMIT = 2000000;

  // One expected output item.
  typedef struct {
    logic [27:0] cur;
    logic [27:0] mn;
    logic [27:0] mx;
    logic [27:0] mean;
    logic [55:0] var_q;
    logic [23:0] mft;
    logic        mzero;
    logic [31:0] seen;
    logic [31:0] dropped;
    logic [6:0]  fill;
  } rate_stats_t;

  // The scoreboard mirrors the window, the counters and both registers.
  class rate_stats_board;
    logic [27:0] rates[DEPTH];
    int unsigned head;
    int unsigned count;
    logic [27:0] last;
    logic [31:0] seen;
    logic [31:0] dropped;
    logic [6:0]  win_reg;
    logic [23:0] thresh_reg;
    rate_stats_t pending[$];
    int          errors;

    function void clear();
      head = 0; count = 0; last = '0; seen = '0; dropped = '0;
      win_reg = 7'd60; thresh_reg = 24'd16670; errors = 0;
      pending.delete();
    endfunction

    function void note_frame(logic [23:0] ft);
      rate_stats_t e;
      int unsigned w, n, idx;
      longint unsigned sum, dsum, q, r1, rem, mean, d;
      longint signed t;
      w = win_reg;
      if (w == 0) w = 1;
      if (w > DEPTH) w = DEPTH;
      if (ft != 0) last = 28'(32'd256000000 / ft);
      seen++;
      if (ft > thresh_reg) dropped++;
      rates[head] = last;
      head = (head + 1) % DEPTH;
      count++;
      if (count > w) count = w;
      n = count;
      sum = 0;
      e.mn = rates[(head + DEPTH - 1) % DEPTH];
      e.mx = e.mn;
      for (int k = 1; k <= n; k++) begin
        idx = (head + DEPTH - k) % DEPTH;
        sum += rates[idx];
        if (rates[idx] < e.mn) e.mn = rates[idx];
        if (rates[idx] > e.mx) e.mx = rates[idx];
      end
      mean = sum / n;
      rem = sum - mean * n;
      dsum = 0;
      for (int k = 1; k <= n; k++) begin
        idx = (head + DEPTH - k) % DEPTH;
        d = (rates[idx] >= mean) ? rates[idx] - mean : mean - rates[idx];
        dsum += d * d;
      end
      q = dsum / n;
      r1 = dsum % n;
      t = longint'(r1 * n) - longint'(rem * rem);
      if (t < 0 && q > 0) q--;
      if (q > 64'h00FF_FFFF_FFFF_FFFF) q = 64'h00FF_FFFF_FFFF_FFFF;
      e.cur = last;
      e.mean = 28'(mean);
      e.var_q = 56'(q);
      e.mzero = (mean == 0);
      if (mean == 0) e.mft = 24'hFF_FFFF;
      else if (256000000 / mean > 24'hFF_FFFF) e.mft = 24'hFF_FFFF;
      else e.mft = 24'(64'd256000000 / mean);
      e.seen = seen;
      e.dropped = dropped;
      e.fill = 7'(n);
      pending = {pending, e};
    endfunction

    function void check_result(rate_stats_t a);
      rate_stats_t e;
      if (pending.size() == 0) begin
        $error("output item with no expected result");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.cur !== e.cur) begin
        $error("current_rate exp %0d got %0d", e.cur, a.cur); errors++;
      end
      if (a.mn !== e.mn) begin
        $error("min_rate exp %0d got %0d", e.mn, a.mn); errors++;
      end
      if (a.mx !== e.mx) begin
        $error("max_rate exp %0d got %0d", e.mx, a.mx); errors++;
      end
      if (a.mean !== e.mean) begin
        $error("mean_rate exp %0d got %0d", e.mean, a.mean); errors++;
      end
      if (a.var_q !== e.var_q) begin
        $error("rate_variance exp %0d got %0d", e.var_q, a.var_q); errors++;
      end
      if (a.mft !== e.mft) begin
        $error("mean_frame_time_us exp %0d got %0d", e.mft, a.mft); errors++;
      end
      if (a.mzero !== e.mzero) begin
        $error("mean_zero exp %0d got %0d", e.mzero, a.mzero); errors++;
      end
      if (a.seen !== e.seen) begin
        $error("frames_seen exp %0d got %0d", e.seen, a.seen); errors++;
      end
      if (a.dropped !== e.dropped) begin
        $error("frames_dropped exp %0d got %0d", e.dropped, a.dropped); errors++;
      end
      if (a.fill !== e.fill) begin
        $error("window_fill exp %0d got %0d", e.fill, a.fill); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [23:0] frame_time_us_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [27:0] current_rate_o, min_rate_o, max_rate_o, mean_rate_o;
  logic [55:0] rate_variance_o;
  logic [23:0] mean_frame_time_us_o;
  logic        mean_zero_o;
  logic [31:0] frames_seen_o, frames_dropped_o;
  logic [6:0]  window_fill_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rate_stats_board board = new();
  int unsigned     cycles = 0;
  bit              out_stall_en = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sliding_window_rate_stats_top u_top (.*);

  // Watchdog: ends the run with a mismatch once the cycle count passes CYC_LIMIT.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("sliding_window_rate_stats_top: mismatch");
      $finish;
    end
  end

  // Result side: the stall hold is redrawn at random per output item.
  // Outputs are sampled at the edge where the item is taken.
  initial begin : out_side
    int unsigned hold;
    rate_stats_t a;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        a.cur = current_rate_o; a.mn = min_rate_o; a.mx = max_rate_o;
        a.mean = mean_rate_o; a.var_q = rate_variance_o;
        a.mft = mean_frame_time_us_o; a.mzero = mean_zero_o;
        a.seen = frames_seen_o; a.dropped = frames_dropped_o;
        a.fill = window_fill_o;
        board.check_result(a);
        hold = out_stall_en ? $urandom_range(0, 9) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Writes one register over the APB-style port; setup then access cycle.
  // The task ends with an idle cycle so that back to back writes keep a clean setup.
  task automatic reg_write(logic idx, logic [31:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == svrs_pkg::REG_WINDOW) board.win_reg = val[6:0];
    else board.thresh_reg = val[23:0];
    @(posedge clk_i);
  endtask

  // Sends one frame time after a random gap and notes it once accepted.
  // Valid drops only for a gap, so consecutive items can follow directly.
  task automatic send_frame(logic [23:0] ft, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_time_us_i <= ft;
    do @(posedge clk_i); while (in_stall_o);
    board.note_frame(ft);
  endtask

  // Waits until all expected items have come, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Frame times spread over short, typical, long and extreme durations.
  function automatic logic [23:0] pick_frame();
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return 24'($urandom_range(1, 300));
      2:       return 24'($urandom);
      3:       return 24'hFF_FFFF - 24'($urandom_range(0, 3));
      default: return 24'($urandom_range(4000, 50000));
    endcase
  endfunction

  initial begin : stim
    int unsigned wins[6];
    board.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero right after reset, extreme durations, the drop
    // threshold boundary, and zero reusing the previous rate.
    send_frame(24'd0, 1'b0);
    send_frame(24'd1, 1'b1);
    send_frame(24'hFF_FFFF, 1'b1);
    send_frame(24'd16670, 1'b0);
    send_frame(24'd16671, 1'b1);
    send_frame(24'd0, 1'b1);
    send_frame(24'd15, 1'b1);
    send_frame(24'haa_aaaa, 1'b0);
    send_frame(24'h55_5555, 1'b1);
    drain();

    // Window zero acts as one; above the depth clamps; threshold extremes.
    reg_write(svrs_pkg::REG_WINDOW, 32'd0);
    reg_write(svrs_pkg::REG_THRESH, 32'd0);
    send_frame(24'd100, 1'b1);
    send_frame(24'd0, 1'b1);
    drain();
    reg_write(svrs_pkg::REG_WINDOW, 32'd127);
    reg_write(svrs_pkg::REG_THRESH, 32'hFF_FFFF);
    for (int i = 0; i < 10; i++) send_frame(pick_frame(), 1'b1);
    drain();

    // Random phases over several window sizes; shrinking trims the window.
    wins = '{64, 1, 2, 17, 64, 5};
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(svrs_pkg::REG_WINDOW, wins[ph]);
      reg_write(svrs_pkg::REG_THRESH, $urandom_range(0, 40000));
      out_stall_en = (ph != 3);
      for (int i = 0; i < 180; i++) send_frame(pick_frame(), ph != 2);
      drain();
    end
    out_stall_en = 1'b1;

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("sliding_window_rate_stats_top: match");
    end else begin
      $display("sliding_window_rate_stats_top: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/svrs_pkg.sv
rtl/svrs_ram.sv
rtl/svrs_div.sv
rtl/svrs_dp.sv
rtl/svrs_ctrl.sv
rtl/sliding_window_rate_stats_top.sv
tb/sliding_window_rate_stats_top_test.sv
